[rtl/pcc_pkg.sv]
// Package for the palette color cycler: sizes, command codes and payload types.
// Used by rtl/palette_color_cycler.sv; depends on nothing.
package pcc_pkg;
  localparam int unsigned SlotCount   = 9;
  localparam int unsigned PaletteSize = 256;
  localparam int unsigned ColorBits   = 24;
  localparam int unsigned IdxW  = $clog2(PaletteSize);
  localparam int unsigned SlotW = $clog2(SlotCount);
  localparam int unsigned LenW  = IdxW + 1;
  localparam int unsigned CapW  = $clog2(SlotCount * PaletteSize);

  typedef enum logic [2:0] {
    CmdWrite  = 3'd0,
    CmdRead   = 3'd1,
    CmdDefine = 3'd2,
    CmdStart  = 3'd3,
    CmdStop   = 3'd4,
    CmdTick   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
    logic [3:0]  slot_number;
    logic [15:0] slot_speed;
    logic [7:0]  range_first;
    logic [7:0]  range_last;
  } in_item_t;

  typedef struct packed {
    logic [23:0] read_color;
    logic [7:0]  read_index;
  } out_item_t;
endpackage

[rtl/palette_color_cycler.sv]
// Palette color cycler top level: live palette and capture memories plus a
// sequencer that walks slot ranges. Depends on rtl/pcc_pkg.sv.
// A read passes StReadRd, StReadWr and, on an output stall, StOutW before
// out_valid_o rises. A write, start, ignored or unused command keeps the input
// free, so the next transfer can follow at the next edge. Define captures via
// StCapRd/StCapWr; a redefine or stop of an active slot restores the old range
// via StRestRd/StRestWr. A tick checks each slot (StTickSl) and restores the
// advancing ones rotated. One command at a time, bounded by the single live
// palette port. Reset clears all slot state at once; memories need no clearing.
module palette_color_cycler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcc_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcc_pkg::out_item_t out_data_o
);
  localparam int unsigned IdxW  = pcc_pkg::IdxW;
  localparam int unsigned SlotW = pcc_pkg::SlotW;
  localparam int unsigned LenW  = pcc_pkg::LenW;
  localparam int unsigned CapW  = pcc_pkg::CapW;
  localparam int unsigned CB    = pcc_pkg::ColorBits;

  // Sequencer states. Each copy step reads in an RD state and writes in the
  // following WR state, since both memories have a registered read port.
  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StReadRd = 9'b000000010,
    StReadWr = 9'b000000100,
    StRestRd = 9'b000001000,  // captured -> live, rotation optional
    StRestWr = 9'b000010000,
    StCapRd  = 9'b000100000,  // live -> captured
    StCapWr  = 9'b001000000,
    StTickSl = 9'b010000000,  // evaluate one slot of a tick
    StOutW   = 9'b100000000
  } state_e;

  state_e state_q;

  // Small per-slot registers.
  logic [pcc_pkg::SlotCount-1:0] def_q, act_q;
  logic [15:0]     spd_q [pcc_pkg::SlotCount];
  logic [15:0]     cnt_q [pcc_pkg::SlotCount];
  logic [IdxW-1:0] pos_q [pcc_pkg::SlotCount];
  logic [IdxW-1:0] base_q[pcc_pkg::SlotCount];
  logic [LenW-1:0] len_q [pcc_pkg::SlotCount];

  // Memories.
  logic [CB-1:0] live_mem[pcc_pkg::PaletteSize];
  logic [CB-1:0] cap_mem [pcc_pkg::SlotCount * pcc_pkg::PaletteSize];
  logic [CB-1:0] live_rd_q, cap_rd_q;

  // Command latch and copy walk.
  pcc_pkg::in_item_t cmd_q;
  logic [SlotW-1:0] sl_q;        // slot in work
  logic [LenW-1:0]  j_q;         // entry within the range
  logic [LenW-1:0]  rot_q;       // (position + j) mod length
  logic [LenW-1:0]  wlen_q;
  logic [IdxW-1:0]  wbase_q;
  logic             tick_mode_q; // restore is part of a tick
  logic             then_cap_q;  // restore is followed by capture (redefine)
  pcc_pkg::out_item_t out_q;
  logic             out_v_q;

  logic live_we, cap_we;
  logic [IdxW-1:0] live_addr;
  logic [CapW-1:0] cap_addr;
  logic [CB-1:0]   live_wdata, cap_wdata;

  logic accept;
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // The output register can take a new read result when it is empty or its
  // current result leaves in this cycle.
  logic out_free, out_load;
  assign out_free = !(out_v_q && out_stall_i);
  assign out_load = ((state_q == StReadWr) || (state_q == StOutW)) && out_free;

  function automatic logic [CapW-1:0] cap_index(logic [SlotW-1:0] s, logic [LenW-1:0] j);
    return CapW'(s) * CapW'(pcc_pkg::PaletteSize) + CapW'(j);
  endfunction

  logic slot_ok;
  logic [SlotW-1:0] in_slot;
  logic [LenW-1:0]  in_len;
  assign slot_ok = in_data_i.slot_number < 4'(pcc_pkg::SlotCount);
  assign in_slot = in_data_i.slot_number[SlotW-1:0];
  assign in_len  = LenW'(in_data_i.range_last) - LenW'(in_data_i.range_first) + LenW'(1);

  // Tick evaluation of slot sl_q.
  logic [16:0]     tcnt;
  logic            tadv;
  logic [IdxW:0]   npos_w;
  logic [IdxW-1:0] npos;
  assign tcnt   = {1'b0, cnt_q[sl_q]} + 17'd1;
  assign tadv   = tcnt > {1'b0, spd_q[sl_q]};
  assign npos_w = {1'b0, pos_q[sl_q]} + 1'b1;
  assign npos   = (npos_w >= len_q[sl_q]) ? '0 : npos_w[IdxW-1:0];

  logic last_j;
  assign last_j = (j_q + 1'b1) == wlen_q;
  logic [LenW-1:0] rot_inc;
  assign rot_inc = ((rot_q + 1'b1) == wlen_q) ? '0 : rot_q + 1'b1;

  // Memory address and write control.
  always_comb begin
    live_we    = 1'b0;
    cap_we     = 1'b0;
    live_addr  = wbase_q + j_q[IdxW-1:0];
    cap_addr   = cap_index(sl_q, j_q);
    live_wdata = cap_rd_q;
    cap_wdata  = live_rd_q;
    unique case (state_q)
      StIdle: begin
        live_addr  = in_data_i.entry_index[IdxW-1:0];
        live_wdata = in_data_i.entry_color[CB-1:0];
        live_we    = accept && (in_data_i.command == pcc_pkg::CmdWrite);
      end
      // The read address is held while the result waits, so live_rd_q stays valid.
      StReadRd, StReadWr, StOutW: live_addr = cmd_q.entry_index[IdxW-1:0];
      StRestWr: begin
        live_addr = wbase_q + rot_q[IdxW-1:0];
        live_we   = 1'b1;
      end
      StCapWr: cap_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (live_we) live_mem[live_addr] <= live_wdata;
    live_rd_q <= live_mem[live_addr];
    if (cap_we) cap_mem[cap_addr] <= cap_wdata;
    cap_rd_q <= cap_mem[cap_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      def_q       <= '0;
      act_q       <= '0;
      out_v_q     <= 1'b0;
      out_q       <= '0;
      cmd_q       <= '0;
      sl_q        <= '0;
      j_q         <= '0;
      rot_q       <= '0;
      wlen_q      <= '0;
      wbase_q     <= '0;
      tick_mode_q <= 1'b0;
      then_cap_q  <= 1'b0;
      for (int s = 0; s < pcc_pkg::SlotCount; s++) begin
        spd_q[s] <= '0; cnt_q[s] <= '0; pos_q[s] <= '0;
        base_q[s] <= '0; len_q[s] <= '0;
      end
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
        out_q.read_color <= 24'(live_rd_q);
        out_q.read_index <= 8'(cmd_q.entry_index[IdxW-1:0]);
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: if (accept) begin
          cmd_q <= in_data_i;
          sl_q  <= in_slot;
          j_q   <= '0;
          unique case (in_data_i.command)
            pcc_pkg::CmdRead:  state_q <= StReadRd;
            pcc_pkg::CmdDefine:
              if (slot_ok && in_data_i.range_first <= in_data_i.range_last) begin
                then_cap_q <= 1'b1;
                tick_mode_q <= 1'b0;
                rot_q   <= '0;
                if (def_q[in_slot] && act_q[in_slot] && len_q[in_slot] != '0) begin
                  wbase_q <= base_q[in_slot];
                  wlen_q  <= len_q[in_slot];
                  state_q <= StRestRd;
                end else begin
                  wbase_q <= in_data_i.range_first;
                  wlen_q  <= in_len;
                  state_q <= StCapRd;
                end
                def_q[in_slot] <= 1'b1;
                act_q[in_slot] <= 1'b0;
                spd_q[in_slot] <= in_data_i.slot_speed;
                cnt_q[in_slot] <= '0;
                pos_q[in_slot] <= '0;
                base_q[in_slot] <= in_data_i.range_first;
                len_q[in_slot] <= in_len;
              end
            pcc_pkg::CmdStart:
              if (slot_ok && def_q[in_slot]) act_q[in_slot] <= 1'b1;
            pcc_pkg::CmdStop:
              if (slot_ok && def_q[in_slot]) begin
                act_q[in_slot] <= 1'b0;
                then_cap_q  <= 1'b0;
                tick_mode_q <= 1'b0;
                wbase_q <= base_q[in_slot];
                wlen_q  <= len_q[in_slot];
                rot_q   <= '0;
                if (act_q[in_slot] && len_q[in_slot] != '0) state_q <= StRestRd;
              end
            pcc_pkg::CmdTick: begin
              sl_q <= '0;
              tick_mode_q <= 1'b1;
              then_cap_q  <= 1'b0;
              state_q <= StTickSl;
            end
            default: ;
          endcase
        end
        StReadRd: state_q <= StReadWr;
        StReadWr, StOutW: state_q <= out_free ? StIdle : StOutW;
        StRestRd: state_q <= StRestWr;
        StRestWr: begin
          if (last_j) begin
            j_q <= '0;
            if (then_cap_q) begin
              wbase_q <= cmd_q.range_first;
              wlen_q  <= len_q[sl_q];
              state_q <= StCapRd;
            end else if (tick_mode_q) begin
              if (sl_q == SlotW'(pcc_pkg::SlotCount - 1)) state_q <= StIdle;
              else begin
                sl_q <= sl_q + 1'b1;
                state_q <= StTickSl;
              end
            end else state_q <= StIdle;
          end else begin
            j_q     <= j_q + 1'b1;
            rot_q   <= rot_inc;
            state_q <= StRestRd;
          end
        end
        StCapRd: state_q <= StCapWr;
        StCapWr: begin
          if (last_j) state_q <= StIdle;
          else begin
            j_q     <= j_q + 1'b1;
            state_q <= StCapRd;
          end
        end
        StTickSl: begin
          priority if (def_q[sl_q] && act_q[sl_q] && tadv && len_q[sl_q] != '0) begin
            cnt_q[sl_q] <= '0;
            pos_q[sl_q] <= npos;
            wbase_q <= base_q[sl_q];
            wlen_q  <= len_q[sl_q];
            rot_q   <= LenW'(npos);
            j_q     <= '0;
            state_q <= StRestRd;
          end else begin
            if (def_q[sl_q] && act_q[sl_q])
              cnt_q[sl_q] <= tadv ? '0 : tcnt[15:0];
            if (sl_q == SlotW'(pcc_pkg::SlotCount - 1)) state_q <= StIdle;
            else sl_q <= sl_q + 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
